FILE: src/hpt_pkg.sv
// Shared types and constants for the homogeneous point transform.
// Used by hpt_div_step and homogeneous_point_transform_top; no dependencies.
`default_nettype none
package hpt_pkg;
	localparam int COEF_WIDTH      = 32;
	localparam int NUM_PAIRS       = 8;
	localparam int NUM_COEFS       = 16;
	localparam int LANES           = 3;
	localparam int CFG_INDEX_WIDTH = 4;
	localparam int CFG_DATA_WIDTH  = 64;

	typedef logic [CFG_DATA_WIDTH-1:0] hpt_pair_t;

	// Identity matrix in Q16.16, column-major, two entries per register.
	localparam hpt_pair_t COEF_RESET [NUM_PAIRS] = '{
		64'd65536, 64'd0, 64'd281474976710656, 64'd0,
		64'd0, 64'd65536, 64'd0, 64'd281474976710656
	};

	// Per-item control carried beside the divider datapath.
	typedef struct packed {
		logic             valid;
		logic             degen;
		logic [LANES-1:0] neg;
		logic [LANES-1:0] big;
		logic [LANES-1:0] dsat;
	} hpt_ctl_t;
endpackage
`default_nettype wire

FILE: src/hpt_div_step.sv
// One restoring-division stage: decides one quotient bit for each of the three lanes.
// Depends on hpt_pkg for the control struct.
`default_nettype none
module hpt_div_step #(
	parameter int SW    = 66,
	parameter int RW    = 114,
	parameter int CW    = 32,
	parameter int SHIFT = 0
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire hpt_pkg::hpt_ctl_t        ctl_prev,
	input  wire logic [SW-1:0]            d_prev,
	input  wire logic [RW-1:0]            r_prev [hpt_pkg::LANES],
	input  wire logic [CW-1:0]            q_prev [hpt_pkg::LANES],
	output hpt_pkg::hpt_ctl_t             ctl_next,
	output logic [SW-1:0]                 d_next,
	output logic [RW-1:0]                 r_next [hpt_pkg::LANES],
	output logic [CW-1:0]                 q_next [hpt_pkg::LANES]
);
	logic [RW-1:0] dsh;
	logic [hpt_pkg::LANES-1:0] take;

	always_comb begin
		dsh = RW'(d_prev) << SHIFT;
		for (int l = 0; l < hpt_pkg::LANES; l++) begin
			take[l] = !ctl_prev.degen && (r_prev[l] >= dsh);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_next <= '0;
		end else begin
			ctl_next <= ctl_prev;
		end
	end

	always_ff @(posedge clk) begin
		d_next <= d_prev;
		for (int l = 0; l < hpt_pkg::LANES; l++) begin
			r_next[l] <= take[l] ? (r_prev[l] - dsh) : r_prev[l];
			q_next[l] <= q_prev[l] | (CW'(take[l]) << SHIFT);
		end
	end
endmodule
`default_nettype wire

FILE: src/homogeneous_point_transform_top.sv
// Homogeneous 4x4 point transform: multiply, sum, pipelined divide, saturate.
// Depends on hpt_pkg and hpt_div_step.
//
// Usage:
//  - Load the matrix through cfg_we / cfg_index / cfg_data; register k holds
//    entries 2k (bits 31..0) and 2k+1 (bits 63..32). Indexes above seven are
//    dropped. Write only while no point is in flight.
//  - Present a point on px/py/pz with start high; busy is always low, so a
//    point transfers at every edge with start high.
//  - The result appears on qx/qy/qz/degenerate_w/saturated with done high for
//    one cycle. One point per cycle sustained.
//  - The divider is restoring: one quotient bit per stage,
//    COORD_WIDTH stages, behind multiply, sum, magnitude and range-check stages.
//  - The receiver cannot stall; every result is shown exactly once.
//  - Reset loads the identity matrix and empties the pipeline.
`default_nettype none
module homogeneous_point_transform_top #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	output logic                                       busy,
	input  wire logic                                  cfg_we,
	input  wire logic [hpt_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
	input  wire logic [hpt_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
	input  wire logic signed [COORD_WIDTH-1:0]         px,
	input  wire logic signed [COORD_WIDTH-1:0]         py,
	input  wire logic signed [COORD_WIDTH-1:0]         pz,
	output logic                                       done,
	output logic signed [COORD_WIDTH-1:0]              qx,
	output logic signed [COORD_WIDTH-1:0]              qy,
	output logic signed [COORD_WIDTH-1:0]              qz,
	output logic                                       degenerate_w,
	output logic                                       saturated
);
	localparam int CW = COORD_WIDTH;
	localparam int FB = FRAC_BITS;
	localparam int CFW = hpt_pkg::COEF_WIDTH;
	localparam int PW = CW + CFW;
	localparam int OW = CFW + FB;
	localparam int SW = ((PW > OW) ? PW : OW) + 2;
	localparam int RW = SW + CW + FB;
	localparam int VW = SW - FB;
	localparam int LN = hpt_pkg::LANES;

	localparam logic [CW-1:0] QMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] QMIN = {1'b1, {(CW-1){1'b0}}};

	// Identity matrix at FRAC_BITS fraction bits
	localparam logic [CFW-1:0] ONE_Q  = CFW'(1) << FB;
	localparam logic [CFW-1:0] ZERO_Q = '0;
	localparam hpt_pkg::hpt_pair_t COEF_INIT [hpt_pkg::NUM_PAIRS] = '{
		{ZERO_Q, ONE_Q}, {ZERO_Q, ZERO_Q}, {ONE_Q, ZERO_Q}, {ZERO_Q, ZERO_Q},
		{ZERO_Q, ZERO_Q}, {ZERO_Q, ONE_Q}, {ZERO_Q, ZERO_Q}, {ONE_Q, ZERO_Q}
	};

	assign busy = 1'b0;

	// Coefficient registers
	hpt_pkg::hpt_pair_t coef_q [hpt_pkg::NUM_PAIRS];
	logic signed [CFW-1:0] m [hpt_pkg::NUM_COEFS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < hpt_pkg::NUM_PAIRS; i++) begin
				coef_q[i] <= COEF_INIT[i];
			end
		end else if (cfg_we &&
				(cfg_index < hpt_pkg::CFG_INDEX_WIDTH'(hpt_pkg::NUM_PAIRS))) begin
			coef_q[cfg_index[$clog2(hpt_pkg::NUM_PAIRS)-1:0]] <= cfg_data;
		end
	end

	always_comb begin
		for (int p = 0; p < hpt_pkg::NUM_PAIRS; p++) begin
			m[2*p]   = coef_q[p][CFW-1:0];
			m[2*p+1] = coef_q[p][2*CFW-1:CFW];
		end
	end

	// Stage 1: products
	logic                 valid_s1;
	logic signed [PW-1:0] prod_s1 [4][3];
	logic signed [CFW-1:0] offs_s1 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < 4; r++) begin
			prod_s1[r][0] <= PW'(m[r])     * PW'(px);
			prod_s1[r][1] <= PW'(m[r + 4]) * PW'(py);
			prod_s1[r][2] <= PW'(m[r + 8]) * PW'(pz);
			offs_s1[r]    <= m[r + 12];
		end
	end

	// Stage 2: homogeneous sums
	logic                 valid_s2;
	logic signed [SW-1:0] sum_s2 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < 4; r++) begin
			sum_s2[r] <= SW'(prod_s1[r][0]) + SW'(prod_s1[r][1]) + SW'(prod_s1[r][2])
				+ (SW'(offs_s1[r]) <<< FB);
		end
	end

	// Stage 3: magnitudes, signs, zero-w fallback values
	hpt_pkg::hpt_ctl_t ctl3;
	hpt_pkg::hpt_ctl_t ctl_s3;
	logic [SW-1:0]     dmag;
	logic [SW-1:0]     nmag [LN];
	logic [CW-1:0]     dq   [LN];
	logic [SW-1:0]     d_s3;
	logic [SW-1:0]     nmag_s3 [LN];
	logic [CW-1:0]     dq_s3   [LN];

	always_comb begin
		logic wneg;
		logic nneg;
		logic signed [SW-1:0] shifted;
		logic [VW-1:0] v;
		logic [VW-CW:0] upper;
		wneg = sum_s2[3][SW-1];
		ctl3 = '0;
		ctl3.valid = valid_s2;
		ctl3.degen = (sum_s2[3] == '0);
		dmag = wneg ? (-sum_s2[3]) : sum_s2[3];
		for (int l = 0; l < LN; l++) begin
			nneg = sum_s2[l][SW-1];
			nmag[l] = nneg ? (-sum_s2[l]) : sum_s2[l];
			ctl3.neg[l] = nneg ^ wneg;
			// Zero w: floor shift, then clamp.
			shifted = sum_s2[l] >>> FB;
			v = shifted[VW-1:0];
			upper = v[VW-1:CW-1];
			if ((upper == '0) || (upper == '1)) begin
				dq[l] = v[CW-1:0];
				ctl3.dsat[l] = 1'b0;
			end else begin
				dq[l] = v[VW-1] ? QMIN : QMAX;
				ctl3.dsat[l] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else begin
			ctl_s3 <= ctl3;
		end
	end

	always_ff @(posedge clk) begin
		d_s3 <= dmag;
		for (int l = 0; l < LN; l++) begin
			nmag_s3[l] <= nmag[l];
			dq_s3[l]   <= dq[l];
		end
	end

	// Stage 4: scale numerators, flag quotients too large for COORD_WIDTH bits
	hpt_pkg::hpt_ctl_t ctl4;
	hpt_pkg::hpt_ctl_t ctl_s4;
	logic [RW-1:0]     nsc [LN];
	logic [SW-1:0]     d_s4;
	logic [RW-1:0]     r_s4 [LN];
	logic [CW-1:0]     q_s4 [LN];

	always_comb begin
		logic [RW-1:0] dtop;
		dtop = RW'(d_s3) << CW;
		ctl4 = ctl_s3;
		for (int l = 0; l < LN; l++) begin
			nsc[l] = RW'(nmag_s3[l]) << FB;
			ctl4.big[l] = !ctl_s3.degen && (nsc[l] >= dtop);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
		end else begin
			ctl_s4 <= ctl4;
		end
	end

	always_ff @(posedge clk) begin
		d_s4 <= d_s3;
		for (int l = 0; l < LN; l++) begin
			r_s4[l] <= nsc[l];
			q_s4[l] <= ctl_s3.degen ? dq_s3[l] : '0;
		end
	end

	// Divider stages, most significant quotient bit first
	hpt_pkg::hpt_ctl_t ctl_p [CW+1];
	logic [SW-1:0]     d_p   [CW+1];
	logic [RW-1:0]     r_p   [CW+1][LN];
	logic [CW-1:0]     q_p   [CW+1][LN];

	assign ctl_p[0] = ctl_s4;
	assign d_p[0]   = d_s4;
	assign r_p[0]   = r_s4;
	assign q_p[0]   = q_s4;

	for (genvar j = 0; j < CW; j++) begin : g_div
		hpt_div_step #(
			.SW(SW),
			.RW(RW),
			.CW(CW),
			.SHIFT(CW - 1 - j)
		) u_step (
			.clk(clk),
			.arst_n(arst_n),
			.ctl_prev(ctl_p[j]),
			.d_prev(d_p[j]),
			.r_prev(r_p[j]),
			.q_prev(q_p[j]),
			.ctl_next(ctl_p[j+1]),
			.d_next(d_p[j+1]),
			.r_next(r_p[j+1]),
			.q_next(q_p[j+1])
		);
	end

	// Output stage: sign and saturate
	hpt_pkg::hpt_ctl_t ctl_f;
	logic [CW-1:0]     val [LN];
	logic [LN-1:0]     sat;

	assign ctl_f = ctl_p[CW];

	always_comb begin
		logic [CW-1:0] q;
		for (int l = 0; l < LN; l++) begin
			q = q_p[CW][l];
			if (ctl_f.degen) begin
				val[l] = q;
				sat[l] = ctl_f.dsat[l];
			end else if (ctl_f.big[l]) begin
				val[l] = ctl_f.neg[l] ? QMIN : QMAX;
				sat[l] = 1'b1;
			end else if (!ctl_f.neg[l]) begin
				sat[l] = q[CW-1];
				val[l] = q[CW-1] ? QMAX : q;
			end else begin
				sat[l] = q[CW-1] && (q[CW-2:0] != '0);
				val[l] = sat[l] ? QMIN : (-q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctl_f.valid;
		end
	end

	always_ff @(posedge clk) begin
		qx           <= val[0];
		qy           <= val[1];
		qz           <= val[2];
		degenerate_w <= ctl_f.degen;
		saturated    <= |sat;
	end
endmodule
`default_nettype wire

FILE: sim/homogeneous_point_transform_top_tb.sv
// Testbench for homogeneous_point_transform_top: directed and random points
// under several matrices. Depends on hpt_pkg and the transform RTL; the
// expected results come from an internal 128-bit predictor.
`timescale 1ns / 1ps
module homogeneous_point_transform_top_tb;
	localparam int CW = 32;
	localparam int FB = 16;
	localparam int LATENCY = CW + 5;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic signed [CW-1:0] QMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] QMIN = {1'b1, {(CW-1){1'b0}}};

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} point_t;

	typedef struct packed {
		logic signed [CW-1:0] qx;
		logic signed [CW-1:0] qy;
		logic signed [CW-1:0] qz;
		logic                 degen;
		logic                 sat;
	} tpoint_t;

	logic clk, arst_n, start, busy, cfg_we, done, degenerate_w, saturated;
	logic [hpt_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
	logic [hpt_pkg::CFG_DATA_WIDTH-1:0] cfg_data;
	logic signed [CW-1:0] px, py, pz, qx, qy, qz;

	homogeneous_point_transform_top dut (.*);

	hpt_pkg::hpt_pair_t matrix [hpt_pkg::NUM_PAIRS];
	point_t pending_points [$];
	tpoint_t expected_points [$];
	int errors = 0;
	int cycles = 0;
	int gap_left = 0;

	function automatic logic signed [31:0] coef_at(int k);
		hpt_pkg::hpt_pair_t p;
		p = matrix[k / 2];
		return (k % 2) ? p[63:32] : p[31:0];
	endfunction

	function automatic logic signed [127:0] row_sum(int r, point_t p);
		logic signed [127:0] s;
		s = 128'(coef_at(r)) * 128'(p.x) + 128'(coef_at(r + 4)) * 128'(p.y)
			+ 128'(coef_at(r + 8)) * 128'(p.z) + (128'(coef_at(r + 12)) <<< FB);
		return s;
	endfunction

	function automatic logic signed [CW-1:0] clamp_coord(logic signed [127:0] v, ref logic sat);
		if (v > 128'(QMAX)) begin
			sat = 1;
			return QMAX;
		end
		if (v < 128'(QMIN)) begin
			sat = 1;
			return QMIN;
		end
		return v[CW-1:0];
	endfunction

	function automatic tpoint_t transform_point(point_t p);
		tpoint_t t;
		logic signed [127:0] w, num, q;
		logic signed [CW-1:0] c [3];
		logic sat;
		sat = 0;
		w = row_sum(3, p);
		for (int r = 0; r < 3; r++) begin
			num = row_sum(r, p);
			// signed division truncates toward zero; the shifted numerator fits in 128 bits
			if (w == 0) q = num >>> FB;
			else q = (num <<< FB) / w;
			c[r] = clamp_coord(q, sat);
		end
		t.qx = c[0];
		t.qy = c[1];
		t.qz = c[2];
		t.degen = (w == 0);
		t.sat = sat;
		return t;
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 7))
			0: return QMAX;
			1: return QMIN;
			2: return 32'($signed($urandom_range(0, 8)) - 4) <<< FB;
			3: return $urandom_range(0, 65535) - 32768;
			4: return ($urandom_range(0, 2000) - 1000) <<< FB;
			default: return $urandom;
		endcase
	endfunction

	function automatic point_t rand_point();
		point_t p;
		p.x = rand_coord();
		p.y = rand_coord();
		p.z = rand_coord();
		return p;
	endfunction

	function automatic point_t mk_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		point_t p;
		p.x = x;
		p.y = y;
		p.z = z;
		return p;
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// driver: one transfer per edge with start high, random gaps between points
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 0;
			px <= '0;
			py <= '0;
			pz <= '0;
		end else begin
			if (start && !busy)
				expected_points.insert(expected_points.size(),
					transform_point(mk_point(px, py, pz)));
			if (gap_left > 0 || pending_points.size() == 0) begin
				start <= 0;
				if (gap_left > 0) gap_left <= gap_left - 1;
			end else begin
				point_t p;
				p = pending_points.pop_front();
				px <= p.x;
				py <= p.y;
				pz <= p.z;
				start <= 1;
				case ($urandom_range(0, 9))
					0, 1: gap_left <= $urandom_range(1, 3);
					2: gap_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(10, 60) : 0;
					default: gap_left <= 0;
				endcase
			end
		end
	end

	// monitor: results cannot be held off, so check each strobe as it comes
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_points.size() == 0) begin
				$error("result with no point in flight: qx=%0d qy=%0d qz=%0d", qx, qy, qz);
				errors++;
			end else begin
				tpoint_t e;
				e = expected_points.pop_front();
				if (qx !== e.qx) begin
					$error("qx: expected %0d, got %0d", e.qx, qx);
					errors++;
				end
				if (qy !== e.qy) begin
					$error("qy: expected %0d, got %0d", e.qy, qy);
					errors++;
				end
				if (qz !== e.qz) begin
					$error("qz: expected %0d, got %0d", e.qz, qz);
					errors++;
				end
				if (degenerate_w !== e.degen) begin
					$error("degenerate_w: expected %0b, got %0b", e.degen, degenerate_w);
					errors++;
				end
				if (saturated !== e.sat) begin
					$error("saturated: expected %0b, got %0b", e.sat, saturated);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// wait until the pipeline is empty, then let it drain fully
	task automatic settle();
		while (pending_points.size() != 0 || start || expected_points.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_pair(int idx, hpt_pkg::hpt_pair_t v);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx[hpt_pkg::CFG_INDEX_WIDTH-1:0];
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
		if (idx < hpt_pkg::NUM_PAIRS) matrix[idx] = v;
	endtask

	task automatic load_random_matrix(int style);
		hpt_pkg::hpt_pair_t v;
		for (int k = 0; k < hpt_pkg::NUM_PAIRS; k++) begin
			case (style)
				0: v = {$urandom, $urandom};
				1: v = {32'($signed($urandom_range(0, 4)) - 2) <<< FB,
					32'($signed($urandom_range(0, 4)) - 2) <<< FB};
				2: v = {32'($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000),
					32'($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000)};
				default: v = {32'($urandom_range(0, 131072)) - 32'd65536,
					32'($urandom_range(0, 131072)) - 32'd65536};
			endcase
			write_pair(k, v);
		end
	endtask

	task automatic add_point(point_t p);
		pending_points.insert(pending_points.size(), p);
	endtask

	task automatic queue_random(int n);
		for (int i = 0; i < n; i++) add_point(rand_point());
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_data = '0;
		for (int k = 0; k < hpt_pkg::NUM_PAIRS; k++) matrix[k] = hpt_pkg::COEF_RESET[k];
		repeat (6) @(posedge clk);
		arst_n <= 1;

		// identity: extremes pass through, w fixed at one
		add_point(mk_point(QMAX, QMIN, 0));
		add_point(mk_point(QMIN, QMAX, 32'hffffffff));
		add_point(mk_point(32'h00010000, 32'hffff0000, 1));
		add_point(mk_point(32'h55555555, 32'haaaaaaaa, 32'h12345678));
		settle();

		// zero w: last row cleared, numerators shifted with floor rounding
		write_pair(7, {32'd0, 32'h00010000});
		write_pair(3, {32'd0, 32'd0});
		write_pair(1, {32'd0, 32'd0});
		write_pair(9, {$urandom, $urandom});
		add_point(mk_point(32'hffffffff, 32'h00000001, 32'h80000000));
		add_point(mk_point(QMAX, QMAX, QMAX));
		add_point(mk_point(0, 0, 0));
		settle();

		// tiny w: large quotients clamp both ways
		write_pair(1, {32'd1, 32'd0});
		write_pair(3, {32'd0, 32'd0});
		write_pair(5, {32'd0, 32'd0});
		write_pair(7, {32'h00000000, 32'h00010000});
		add_point(mk_point(QMAX, 32'hffffffff, 0));
		add_point(mk_point(QMIN, 32'h00000001, 32'h00010000));
		add_point(mk_point(32'h00000001, 0, 0));
		add_point(mk_point(32'hffffffff, 0, 0));
		add_point(mk_point(0, 0, 0));
		settle();

		// extreme coefficients everywhere
		for (int k = 0; k < hpt_pkg::NUM_PAIRS; k++) write_pair(k, {32'h80000000, 32'h7fffffff});
		add_point(mk_point(QMIN, QMIN, QMIN));
		add_point(mk_point(QMAX, QMIN, QMAX));
		add_point(mk_point(QMAX, QMAX, QMAX));
		settle();
		for (int k = 0; k < hpt_pkg::NUM_PAIRS; k++) write_pair(k, '1);
		add_point(mk_point(QMIN, QMAX, 32'h00010000));
		settle();
		for (int k = 0; k < hpt_pkg::NUM_PAIRS; k++) write_pair(k, '0);
		add_point(mk_point(QMAX, QMIN, 5));
		settle();

		for (int phase = 0; phase < 8; phase++) begin
			load_random_matrix(phase % 4);
			queue_random(75);
			settle();
		end

		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
